### sv/htbp_pkg.sv
// ----------------------------------------------------------------------------
// htbp_pkg
// Shared types, constants and helpers for the huffman table bit packer.
// ----------------------------------------------------------------------------
package htbp_pkg;

  localparam int CODE_W           = 16;
  localparam int LEN_IN_W         = 5;
  localparam int SYM_W            = 8;
  localparam int BYTE_W           = 8;
  localparam int PEND_W           = 7;
  localparam int PEND_CNT_W       = 3;
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int SYMBOL_COUNT_DEF = 256;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  function automatic int htbp_len_bound(input int max_len);
    return (max_len > CODE_W) ? CODE_W : max_len;
  endfunction

  function automatic int htbp_max_bytes(input int max_len);
    return (PEND_W + htbp_len_bound(max_len)) / BYTE_W;
  endfunction

endpackage

### sv/huffman_table_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_table_bit_packer
// Huffman code packer with two loadable code tables, MSB-first byte output.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one transaction per cycle:
// while in_stall is low: a load writes a code and its length into the
// selected table, an encode appends the symbol's code to the bit
// accumulator, a flush pads and sends the partial byte. Result channel
// (out_valid / out_stall) gives one byte per transaction, out_last
// marking the final byte of an input item.
// An item is read from the table memory when it is accepted; the pack
// stage works on the registered lookup result and writes its bytes
// into the output queue, which drives out_.
// Throughput: one item per cycle while in_stall is low; an encode can
// make up to two bytes and the output port moves one byte a cycle while
// out_stall is low, so the output queue sets the sustained rate.
// Reset: the length table is cleared entry by entry, all 2*SYMBOL_COUNT
// entries (512 at defaults); in_stall stays high during that pass.
// A stalled receiver fills the output queue; once it cannot take the
// largest burst of one item, the packing stage holds and in_stall rises.
// ----------------------------------------------------------------------------
module huffman_table_bit_packer
  import htbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_operation,
  input  logic                in_table_select,
  input  logic [SYM_W-1:0]    in_symbol,
  input  logic [CODE_W-1:0]   in_code_bits,
  input  logic [LEN_IN_W-1:0] in_code_length,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_last
);

  localparam int LEN_BOUND = htbp_len_bound(MAX_CODE_LEN);
  localparam int LEN_MW    = $clog2(LEN_BOUND + 1);
  localparam int ADDR_W    = $clog2(2 * SYMBOL_COUNT);
  localparam int MAX_BYTES = htbp_max_bytes(MAX_CODE_LEN);
  localparam int PN_W      = $clog2(MAX_BYTES + 1);
  localparam int FREE_W    = $clog2(2 * MAX_BYTES) + 1;

  op_t                 op;
  logic                in_acc;
  logic                sym_ok;
  logic [ADDR_W-1:0]   addr;
  logic [LEN_MW-1:0]   len_sat;
  logic                tbl_wr;
  logic                tbl_busy;
  logic [CODE_W-1:0]   rd_code;
  logic [LEN_MW-1:0]   rd_len;
  logic                pack_ready;
  logic [FREE_W-1:0]   fifo_free;
  logic [PN_W-1:0]     push_n;
  logic [BYTE_W-1:0]   push_byte [MAX_BYTES];
  logic [MAX_BYTES-1:0] push_last;

  assign op       = op_t'(in_operation);
  assign in_stall = tbl_busy || !pack_ready;
  assign in_acc   = in_valid && !in_stall;
  assign sym_ok   = ((SYM_W + 1)'(in_symbol) < (SYM_W + 1)'(SYMBOL_COUNT));
  assign addr     = in_table_select ? (ADDR_W'(SYMBOL_COUNT) + ADDR_W'(in_symbol))
                                    : ADDR_W'(in_symbol);
  assign len_sat  = ((LEN_IN_W + 1)'(in_code_length) > (LEN_IN_W + 1)'(LEN_BOUND))
                    ? LEN_MW'(LEN_BOUND) : LEN_MW'(in_code_length);
  assign tbl_wr   = in_acc && (op == OP_LOAD) && sym_ok;

  htbp_table #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (tbl_wr),
    .wr_addr(addr),
    .wr_code(in_code_bits),
    .wr_len (len_sat),
    .rd_en  (in_acc),
    .rd_addr(addr),
    .rd_code(rd_code),
    .rd_len (rd_len),
    .busy   (tbl_busy)
  );

  htbp_pack #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_acc),
    .op       (op),
    .sym_ok   (sym_ok),
    .rd_code  (rd_code),
    .rd_len   (rd_len),
    .fifo_free(fifo_free),
    .ready    (pack_ready),
    .push_n   (push_n),
    .push_byte(push_byte),
    .push_last(push_last)
  );

  htbp_fifo #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (push_n),
    .push_byte(push_byte),
    .push_last(push_last),
    .free     (fifo_free),
    .out_valid(out_valid),
    .out_byte (out_byte),
    .out_last (out_last),
    .out_stall(out_stall)
  );

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_busy |-> in_stall)
    else $error("input taken during table clear");

  a_clear_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_busy |-> !out_valid)
    else $error("output during table clear");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != '0) |-> (fifo_free >= FREE_W'(push_n)))
    else $error("output queue overflow");

  a_flush_single: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != '0) |-> (((push_last >> (push_n - 1'b1)) & MAX_BYTES'(1)) != '0))
    else $error("burst without last marker");

endmodule

### sv/htbp_table.sv
// ----------------------------------------------------------------------------
// htbp_table
// Code and length tables for both symbol sets, with a clearing pass of the
// length table after reset.
// ----------------------------------------------------------------------------
module htbp_table
  import htbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  localparam int LEN_BOUND   = htbp_len_bound(MAX_CODE_LEN),
  localparam int LEN_MW      = $clog2(LEN_BOUND + 1),
  localparam int DEPTH       = 2 * SYMBOL_COUNT,
  localparam int ADDR_W      = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CODE_W-1:0] wr_code,
  input  logic [LEN_MW-1:0] wr_len,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CODE_W-1:0] rd_code,
  output logic [LEN_MW-1:0] rd_len,
  output logic              busy
);

  logic [CODE_W-1:0] code_mem [DEPTH];
  logic [LEN_MW-1:0] len_mem  [DEPTH];
  logic              clr_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [CODE_W-1:0] rd_code_r;
  logic [LEN_MW-1:0] rd_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      len_mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      len_mem[wr_addr] <= wr_len;
    end
    if (rd_en) begin
      rd_len_r <= len_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !clr_r) begin
      code_mem[wr_addr] <= wr_code;
    end
    if (rd_en) begin
      rd_code_r <= code_mem[rd_addr];
    end
  end

  assign rd_code = rd_code_r;
  assign rd_len  = rd_len_r;
  assign busy    = clr_r;

endmodule

### sv/htbp_pack.sv
// ----------------------------------------------------------------------------
// htbp_pack
// Lookup result stage: merges the code with the pending bits, splits off
// whole bytes and keeps the partial byte; a flush pads and sends it.
// ----------------------------------------------------------------------------
module htbp_pack
  import htbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  localparam int LEN_BOUND   = htbp_len_bound(MAX_CODE_LEN),
  localparam int LEN_MW      = $clog2(LEN_BOUND + 1),
  localparam int ACC_W       = PEND_W + LEN_BOUND,
  localparam int CNT_W       = $clog2(ACC_W + 1),
  localparam int MAX_BYTES   = htbp_max_bytes(MAX_CODE_LEN),
  localparam int PN_W        = $clog2(MAX_BYTES + 1),
  localparam int FREE_W      = $clog2(2 * MAX_BYTES) + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  op_t               op,
  input  logic              sym_ok,
  input  logic [CODE_W-1:0] rd_code,
  input  logic [LEN_MW-1:0] rd_len,
  input  logic [FREE_W-1:0] fifo_free,
  output logic              ready,
  output logic [PN_W-1:0]   push_n,
  output logic [BYTE_W-1:0] push_byte [MAX_BYTES],
  output logic [MAX_BYTES-1:0] push_last
);

  logic                  s1_valid_r;
  op_t                   s1_op_r;
  logic                  s1_sym_ok_r;
  logic [PEND_W-1:0]     pend_bits_r, pend_bits_nxt;
  logic [PEND_CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic                  go;
  logic [LEN_MW-1:0]     len;
  logic [CODE_W-1:0]     code_masked;
  logic [ACC_W-1:0]      acc;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      shamt;
  logic [PN_W-1:0]       nbytes;
  logic [PEND_CNT_W-1:0] rem;
  logic [BYTE_W-1:0]     flush_byte;

  assign go    = s1_valid_r && (fifo_free >= FREE_W'(MAX_BYTES));
  assign ready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      if (load) begin
        s1_valid_r <= 1'b1;
      end else if (go) begin
        s1_valid_r <= 1'b0;
      end
      if (go) begin
        pend_bits_r <= pend_bits_nxt;
        pend_cnt_r  <= pend_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_op_r     <= op;
      s1_sym_ok_r <= sym_ok;
    end
  end

  always_comb begin
    len         = s1_sym_ok_r ? rd_len : '0;
    code_masked = rd_code & ~({CODE_W{1'b1}} << len);
    acc         = (ACC_W'(pend_bits_r) << len) | ACC_W'(code_masked);
    cnt         = CNT_W'(pend_cnt_r) + CNT_W'(len);
    nbytes      = PN_W'(cnt >> 3);
    rem         = cnt[PEND_CNT_W-1:0];
    flush_byte  = BYTE_W'({1'b0, pend_bits_r} << (4'd8 - {1'b0, pend_cnt_r}));

    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    push_n        = '0;
    push_last     = '0;
    for (int k = 0; k < MAX_BYTES; k++) begin
      shamt        = cnt - CNT_W'(BYTE_W * (k + 1));
      push_byte[k] = BYTE_W'(acc >> shamt);
    end

    case (s1_op_r)
      OP_ENCODE: begin
        if (len != '0) begin
          push_n        = nbytes;
          pend_bits_nxt = PEND_W'(acc) & ~({PEND_W{1'b1}} << rem);
          pend_cnt_nxt  = rem;
          for (int k = 0; k < MAX_BYTES; k++) begin
            push_last[k] = (PN_W'(k + 1) == nbytes);
          end
        end
      end
      OP_FLUSH: begin
        if (pend_cnt_r != '0) begin
          push_n       = PN_W'(1);
          push_byte[0] = flush_byte;
          push_last    = MAX_BYTES'(1);
        end
        pend_bits_nxt = '0;
        pend_cnt_nxt  = '0;
      end
      default: begin
      end
    endcase

    if (!go) begin
      push_n = '0;
    end
  end

endmodule

### sv/htbp_fifo.sv
// ----------------------------------------------------------------------------
// htbp_fifo
// Output byte queue: takes up to MAX_BYTES bytes per cycle, gives one per
// transaction.
// ----------------------------------------------------------------------------
module htbp_fifo
  import htbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  localparam int MAX_BYTES   = htbp_max_bytes(MAX_CODE_LEN),
  localparam int PN_W        = $clog2(MAX_BYTES + 1),
  localparam int AW          = $clog2(2 * MAX_BYTES),
  localparam int DEPTH       = 2 ** AW,
  localparam int FREE_W      = AW + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PN_W-1:0]   push_n,
  input  logic [BYTE_W-1:0] push_byte [MAX_BYTES],
  input  logic [MAX_BYTES-1:0] push_last,
  output logic [FREE_W-1:0] free,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  input  logic              out_stall
);

  logic [BYTE_W-1:0] byte_mem [DEPTH];
  logic              last_mem [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [FREE_W-1:0] count_r;
  logic              pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count_r != '0);
  assign out_byte  = byte_mem[rd_ptr_r];
  assign out_last  = last_mem[rd_ptr_r];
  assign free      = FREE_W'(DEPTH) - count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + AW'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + FREE_W'(push_n) - FREE_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_BYTES; k++) begin
      if (PN_W'(k) < push_n) begin
        byte_mem[wr_ptr_r + AW'(k)] <= push_byte[k];
        last_mem[wr_ptr_r + AW'(k)] <= push_last[k];
      end
    end
  end

endmodule
